// ===== sv/shsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shsu_pkg
// Shared widths, codes, command and status types and the bit count function
// of the sign Hamming score update block.
// ----------------------------------------------------------------------------
package shsu_pkg;

  localparam int QWORDS   = 32;
  localparam int QIDX_W   = $clog2(QWORDS);
  localparam int WORD_W   = 32;
  localparam int PC_W     = 11;
  localparam int HAM_W    = 11;
  localparam int DOT_W    = 13;
  localparam int PROD_W   = 45;
  localparam int MAG_W    = 44;
  localparam int NPART_W  = 16;
  localparam int PPROD_W  = MAG_W + NPART_W;
  localparam int RND_W    = PPROD_W + 1;
  localparam int SUM_W    = 53;
  localparam int CAP_W    = 34;
  localparam int DELTA_W  = CAP_W + 1;
  localparam int TOTAL_W  = 36;
  localparam int TOKEN_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int S_TDATA_W  = 120;
  localparam int M_TDATA_W  = 48;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_TOKEN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PROJ_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_SCALE = 1'd1;

  localparam logic [PC_W-1:0]   PROJ_COUNT_RESET  = 11'd1024;
  localparam logic [WORD_W-1:0] SCORE_SCALE_RESET = 32'h0100_0000;

  localparam logic [HAM_W-1:0]  HAM_MAX   = 11'd2047;
  localparam logic [CAP_W-1:0]  MAG_CAP   = 34'h2_0000_0000;
  localparam logic [RND_W-1:0]  RND_HALF  = 61'h80_0000;
  localparam logic signed [TOTAL_W-1:0] SCORE_MAX = 36'sd2147483647;
  localparam logic signed [TOTAL_W-1:0] SCORE_MIN = -36'sd2147483648;

  localparam logic [WORD_W-1:0] M1 = 32'h5555_5555;
  localparam logic [WORD_W-1:0] M2 = 32'h3333_3333;
  localparam logic [WORD_W-1:0] M4 = 32'h0F0F_0F0F;

  typedef struct packed {
    logic load_query;
    logic load_token;
    logic pop;
    logic dot;
    logic prod;
    logic absval;
    logic mul_hi;
    logic mul_lo;
    logic rnd;
    logic acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_last;
    logic out_busy;
  } status_t;

  function automatic logic [5:0] bits_set(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = w - ((w >> 1) & M1);
    v = (v & M2) + ((v >> 2) & M2);
    v = (v + (v >> 4)) & M4;
    return 6'(v[7:0]) + 6'(v[15:8]) + 6'(v[23:16]) + 6'(v[31:24]);
  endfunction

endpackage
`default_nettype wire

// ===== sv/sign_hamming_score_update_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sign_hamming_score_update_top
// Query words are loaded with tuser 0; token words with tuser 1 are XORed with
// the stored query word, bit counted and summed, and on a token's last word the
// block emits base_score + scale * norm * (projection_count - 2 * hamming) as
// a saturating signed Q16.16 score. A query word is written to the query
// memory; a token word that is not the last takes a memory read, then bit count
// and add, and a last word goes on through the controller's walk through the
// sign dot, signed product, two 44x16 partial products on one shared multiplier,
// rounding and the final add. A finished score waits in the output register
// while the next word is taken. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module sign_hamming_score_update_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // word_index[4:0], sign_word[36:5], residual_norm[68:37],
  // base_score[100:69], token_index[116:101], zero fill[119:117]
  input  wire logic [shsu_pkg::S_TDATA_W-1:0]    s_tdata,
  // func[0]
  input  wire logic                              s_tuser,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // token_out[15:0], score[47:16]
  output logic [shsu_pkg::M_TDATA_W-1:0]         m_tdata,
  // saturated[0]
  output logic                                   m_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  input  wire logic                              cfg_wr_en,
  input  wire logic [shsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [shsu_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

  shsu_pkg::cmd_t    cmd;
  shsu_pkg::status_t status;

  shsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .status   (status)
  );

  shsu_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .s_tdata     (s_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
`default_nettype wire

// ===== sv/shsu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shsu_ctrl
// Sequencer that steps the datapath through bit count, sign dot product,
// scaling multiplies, rounding and the final saturating add.
// ----------------------------------------------------------------------------
module shsu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  input  wire logic              s_tuser,
  output logic                   s_tready,
  output shsu_pkg::cmd_t         cmd,
  input  wire shsu_pkg::status_t status
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POP  = 4'd1;
  localparam logic [3:0] S_DOT  = 4'd2;
  localparam logic [3:0] S_PROD = 4'd3;
  localparam logic [3:0] S_ABS  = 4'd4;
  localparam logic [3:0] S_MHI  = 4'd5;
  localparam logic [3:0] S_MLO  = 4'd6;
  localparam logic [3:0] S_RND  = 4'd7;
  localparam logic [3:0] S_ACC  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    cmd.load_query = accept && (s_tuser == shsu_pkg::FUNC_QUERY);
    cmd.load_token = accept && (s_tuser == shsu_pkg::FUNC_TOKEN);
    case (state)
      S_IDLE: begin
        if (cmd.load_token) begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = status.is_last ? S_DOT : S_IDLE;
      end
      S_DOT: begin
        cmd.dot    = 1'b1;
        state_next = S_PROD;
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.absval = 1'b1;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/shsu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shsu_datapath
// Query word memory, Hamming accumulator, shared scaling multiplier and the
// output word register.
// ----------------------------------------------------------------------------
module shsu_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire shsu_pkg::cmd_t                       cmd,
  output shsu_pkg::status_t                         status,
  input  wire logic [shsu_pkg::S_TDATA_W-1:0]       s_tdata,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [shsu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [shsu_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [shsu_pkg::M_TDATA_W-1:0]            m_tdata,
  output logic                                      m_tuser
);

  logic [shsu_pkg::WORD_W-1:0]         qmem [shsu_pkg::QWORDS];
  logic [shsu_pkg::WORD_W-1:0]         q_rd;
  logic [shsu_pkg::PC_W-1:0]           proj_count;
  logic signed [shsu_pkg::WORD_W-1:0]  score_scale;
  logic [shsu_pkg::QIDX_W-1:0]         idx;
  logic [shsu_pkg::WORD_W-1:0]         word;
  logic [shsu_pkg::WORD_W-1:0]         norm;
  logic signed [shsu_pkg::WORD_W-1:0]  base;
  logic [shsu_pkg::TOKEN_W-1:0]        token;
  logic [shsu_pkg::HAM_W-1:0]          hamming;
  logic [shsu_pkg::HAM_W:0]            ham_sum;
  logic [6:0]                          words;
  logic [6:0]                          words_clamped;
  logic [shsu_pkg::QIDX_W-1:0]         last_idx;
  logic signed [shsu_pkg::DOT_W-1:0]   proj_dot;
  logic signed [shsu_pkg::PROD_W-1:0]  prod;
  logic                                neg;
  logic [shsu_pkg::MAG_W-1:0]          mag;
  logic [shsu_pkg::NPART_W-1:0]        mul_b;
  logic [shsu_pkg::PPROD_W-1:0]        mul_p;
  logic [shsu_pkg::PPROD_W-1:0]        x;
  logic [shsu_pkg::PPROD_W-1:0]        y;
  logic [shsu_pkg::RND_W-1:0]          t;
  logic [shsu_pkg::SUM_W-1:0]          mag_sum;
  logic [shsu_pkg::CAP_W-1:0]          mag_cap;
  logic signed [shsu_pkg::DELTA_W-1:0] delta;
  logic signed [shsu_pkg::TOTAL_W-1:0] total;

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qmem[s_tdata[4:0]] <= s_tdata[36:5];
    end
    if (cmd.load_token) begin
      q_rd <= qmem[s_tdata[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_count  <= shsu_pkg::PROJ_COUNT_RESET;
      score_scale <= shsu_pkg::SCORE_SCALE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        shsu_pkg::REG_PROJ_COUNT:  proj_count  <= cfg_wr_data[shsu_pkg::PC_W-1:0];
        shsu_pkg::REG_SCORE_SCALE: score_scale <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    words = 7'((12'(proj_count) + 12'd31) >> 5);
    if (words == 7'd0) begin
      words_clamped = 7'd1;
    end else if (words > 7'(shsu_pkg::QWORDS)) begin
      words_clamped = 7'(shsu_pkg::QWORDS);
    end else begin
      words_clamped = words;
    end
    last_idx = shsu_pkg::QIDX_W'(words_clamped - 7'd1);
  end

  assign ham_sum = (shsu_pkg::HAM_W + 1)'(hamming)
                 + (shsu_pkg::HAM_W + 1)'(shsu_pkg::bits_set(q_rd ^ word));
  assign status.is_last  = (idx == last_idx);
  assign status.out_busy = m_tvalid && !m_tready;

  assign mul_b = cmd.mul_hi ? norm[31:16] : norm[15:0];
  assign mul_p = shsu_pkg::PPROD_W'(mag) * shsu_pkg::PPROD_W'(mul_b);

  always_comb begin
    mag_sum = shsu_pkg::SUM_W'(x >> 8) + shsu_pkg::SUM_W'(t >> 24);
    mag_cap = (mag_sum > shsu_pkg::SUM_W'(shsu_pkg::MAG_CAP)) ?
              shsu_pkg::MAG_CAP : mag_sum[shsu_pkg::CAP_W-1:0];
    total   = shsu_pkg::TOTAL_W'(base) + shsu_pkg::TOTAL_W'(delta);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_token) begin
      idx   <= s_tdata[4:0];
      word  <= s_tdata[36:5];
      norm  <= s_tdata[68:37];
      base  <= s_tdata[100:69];
      token <= s_tdata[116:101];
    end
    if (cmd.dot) begin
      proj_dot <= $signed({2'b00, proj_count}) - $signed({1'b0, hamming, 1'b0});
    end
    if (cmd.prod) begin
      prod <= shsu_pkg::PROD_W'(score_scale) * shsu_pkg::PROD_W'(proj_dot);
    end
    if (cmd.absval) begin
      neg <= prod[shsu_pkg::PROD_W-1];
      mag <= shsu_pkg::MAG_W'(prod[shsu_pkg::PROD_W-1] ? -prod : prod);
    end
    if (cmd.mul_hi) begin
      x <= mul_p;
    end
    if (cmd.mul_lo) begin
      y <= mul_p;
    end
    if (cmd.rnd) begin
      t <= shsu_pkg::RND_W'({x[7:0], 16'h0000}) + shsu_pkg::RND_W'(y) + shsu_pkg::RND_HALF;
    end
    if (cmd.acc) begin
      delta <= neg ? -$signed({1'b0, mag_cap}) : $signed({1'b0, mag_cap});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hamming <= '0;
    end else if (cmd.dot) begin
      hamming <= '0;
    end else if (cmd.pop) begin
      hamming <= (ham_sum > (shsu_pkg::HAM_W + 1)'(shsu_pkg::HAM_MAX)) ?
                 shsu_pkg::HAM_MAX : ham_sum[shsu_pkg::HAM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata[15:0] <= token;
      if (total > shsu_pkg::SCORE_MAX) begin
        m_tdata[47:16] <= shsu_pkg::SCORE_MAX[31:0];
        m_tuser        <= 1'b1;
      end else if (total < shsu_pkg::SCORE_MIN) begin
        m_tdata[47:16] <= shsu_pkg::SCORE_MIN[31:0];
        m_tuser        <= 1'b1;
      end else begin
        m_tdata[47:16] <= total[31:0];
        m_tuser        <= 1'b0;
      end
    end
  end

  a_out_load_sets_valid : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("result word not presented after load");

  a_sum_cleared : assert property (@(posedge clk) disable iff (rst)
    cmd.dot |=> (hamming == '0))
    else $error("Hamming sum not cleared after token end");

  a_sat_extreme : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[47:16] == 32'h7FFF_FFFF || m_tdata[47:16] == 32'h8000_0000))
    else $error("saturated flag set on a score that is not clamped");

  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("output word overwritten while stalled");

endmodule
`default_nettype wire
